### hdl/mrcs_pkg.sv
// ----------------------------------------------------------------------------
// Modbus RTU coil slave package
// Shared types, constants and the CRC-16 byte update.
// ----------------------------------------------------------------------------
package mrcs_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;
    localparam logic [7:0]  FN_WRITE_COILS = 8'd15;
    localparam logic [7:0]  FN_WRITE_REGS  = 8'd16;
    localparam logic [7:0]  FN_READ_HOLD   = 8'd3;
    localparam logic [7:0]  FN_READ_INPUT  = 8'd4;
    localparam logic [7:0]  EXC_FLAG       = 8'h80;
    localparam logic [7:0]  EXC_ILLEGAL_FN = 8'd1;
    localparam logic [7:0]  EXC_ILLEGAL_ADDR = 8'd2;
    localparam logic [7:0]  EXC_CRC        = 8'd8;
    localparam logic [7:0]  CFG_SLAVE_ADDR = 8'd0;
    localparam logic [7:0]  CFG_GAP_TICKS  = 8'd1;
    localparam int          HDR_BYTES      = 9;

    // One response to be sent: header bytes, and for an echo the coil update.
    typedef struct packed {
        logic             echo;
        logic [5:0][7:0]  hdr;
        logic [15:0]      mask;
        logic [15:0]      data;
    } t_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

### hdl/mrcs_fifo.sv
// ----------------------------------------------------------------------------
// Command queue
// Two-entry queue between the frame receiver and the response sender.
// ----------------------------------------------------------------------------
module mrcs_fifo import mrcs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_cmd o_cmd
);
    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) r_wr <= ~r_wr;
            if (i_pop)  r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty)) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count out of range");

endmodule

### hdl/mrcs_front.sv
// ----------------------------------------------------------------------------
// Frame receiver
// Tracks line idle time, assembles request frames, checks them and queues
// one response command per frame addressed to this station.
// ----------------------------------------------------------------------------
module mrcs_front import mrcs_pkg::*; #(
    parameter int NUM_COILS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_take,
    input  logic       i_kind,
    input  logic [7:0] i_rx_byte,
    input  logic [7:0] i_slave_addr,
    input  logic [7:0] i_gap_ticks,
    output logic       o_push,
    output t_cmd       o_cmd
);
    logic [7:0]  r_idle;
    logic        r_receiving;
    logic [8:0]  r_idx;
    logic [8:0]  r_exp;
    logic [15:0] r_crc;
    logic [7:0]  r_hdr [HDR_BYTES];

    logic        gap;
    logic        recv;
    logic [8:0]  idx;
    logic [8:0]  idx_n;
    logic [8:0]  exp_n;
    logic [15:0] crc_n;
    logic        done;
    logic [7:0]  byte8;
    logic [15:0] start;
    logic [15:0] qty;
    logic        bound_bad;

    assign gap   = r_idle > i_gap_ticks;
    assign recv  = gap || r_receiving;
    assign idx   = gap ? 9'd0 : r_idx;
    assign idx_n = idx + 9'd1;
    assign crc_n = crc_byte(gap ? CRC_INIT : r_crc, i_rx_byte);

    always_comb begin
        exp_n = r_exp;
        if (idx == 9'd6) begin
            if (r_hdr[1] == FN_WRITE_COILS || r_hdr[1] == FN_WRITE_REGS) begin
                exp_n = 9'd9 + {1'b0, i_rx_byte};
            end else if (r_hdr[1] == FN_READ_HOLD || r_hdr[1] == FN_READ_INPUT) begin
                exp_n = 9'd8;
            end else begin
                exp_n = 9'd7;
            end
        end
    end

    assign done = i_take && !i_kind && recv && (idx_n == exp_n);

    // The high data byte may be the closing byte of the frame itself.
    assign byte8     = (idx == 9'd8) ? i_rx_byte : r_hdr[8];
    assign start     = {r_hdr[2], r_hdr[3]};
    assign qty       = {r_hdr[4], r_hdr[5]};
    assign bound_bad = ({1'b0, start} + {1'b0, qty}) > 17'(NUM_COILS);

    always_comb begin
        o_cmd      = '0;
        o_cmd.hdr[0] = r_hdr[0];
        o_cmd.data = {byte8, r_hdr[7]};
        o_cmd.mask = (qty >= 16'd16) ? 16'hFFFF : 16'((17'd1 << qty[4:0]) - 17'd1);
        priority if (r_hdr[1] != FN_WRITE_COILS) begin
            o_cmd.hdr[1] = r_hdr[1] | EXC_FLAG;
            o_cmd.hdr[2] = EXC_ILLEGAL_FN;
        end else if (crc_n != 16'h0000) begin
            o_cmd.hdr[1] = FN_WRITE_COILS | EXC_FLAG;
            o_cmd.hdr[2] = EXC_CRC;
        end else if (bound_bad) begin
            o_cmd.hdr[1] = FN_WRITE_COILS | EXC_FLAG;
            o_cmd.hdr[2] = EXC_ILLEGAL_ADDR;
        end else begin
            o_cmd.echo   = 1'b1;
            o_cmd.hdr[1] = r_hdr[1];
            o_cmd.hdr[2] = r_hdr[2];
            o_cmd.hdr[3] = r_hdr[3];
            o_cmd.hdr[4] = r_hdr[4];
            o_cmd.hdr[5] = r_hdr[5];
        end
    end

    assign o_push = done && (r_hdr[0] == i_slave_addr);

    always_ff @(posedge i_clk) begin
        if (i_take && !i_kind && recv && idx < 9'(HDR_BYTES)) begin
            r_hdr[idx[3:0]] <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idle      <= 8'hFF;
            r_receiving <= 1'b0;
            r_idx       <= 9'd0;
            r_exp       <= 9'd0;
            r_crc       <= CRC_INIT;
        end else if (i_take) begin
            if (i_kind) begin
                if (r_idle != 8'hFF) r_idle <= r_idle + 8'd1;
            end else begin
                r_idle <= 8'd0;
                if (recv) begin
                    r_crc <= crc_n;
                    if (done) begin
                        r_receiving <= 1'b0;
                        r_idx       <= 9'd0;
                        r_exp       <= 9'd0;
                    end else begin
                        r_receiving <= 1'b1;
                        r_idx       <= idx_n;
                        r_exp       <= exp_n;
                    end
                end
            end
        end
    end

    a_idle_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_take && !i_kind) |=> (r_idle == 8'd0)) else $error("idle count not cleared");
    a_len_known: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_receiving && r_idx > 9'd6) |-> (r_exp != 9'd0)) else $error("length unknown");

endmodule

### hdl/mrcs_back.sv
// ----------------------------------------------------------------------------
// Response sender
// Takes one command at a time, applies the coil write and serialises the
// response with its CRC into a registered output beat.
// ----------------------------------------------------------------------------
module mrcs_back import mrcs_pkg::*; #(
    parameter int NUM_COILS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_cmd        i_cmd,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_last,
    output logic [15:0] o_coils,
    output logic        o_coils_updated
);
    localparam logic [15:0] CoilMask = 16'((32'd1 << NUM_COILS) - 32'd1);

    logic        r_busy;
    t_cmd        r_cmd;
    logic [2:0]  r_k;
    logic [15:0] r_crc;
    logic [15:0] r_coils;
    logic        r_valid;
    logic [7:0]  r_byte;
    logic        r_last;
    logic [15:0] r_ocoils;
    logic        r_upd;

    logic        emit;
    logic [2:0]  last_k;
    logic [7:0]  cur;

    assign o_pop  = !r_busy && !i_empty;
    assign emit   = r_busy && (!r_valid || i_ready);
    assign last_k = r_cmd.echo ? 3'd7 : 3'd4;

    always_comb begin
        if (r_k == last_k) begin
            cur = r_crc[15:8];
        end else if (r_k == last_k - 3'd1) begin
            cur = r_crc[7:0];
        end else begin
            cur = r_cmd.hdr[r_k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_coils <= '0;
            r_k     <= 3'd0;
            r_crc   <= CRC_INIT;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            if (o_pop) begin
                r_busy <= 1'b1;
                r_cmd  <= i_cmd;
                r_k    <= 3'd0;
                r_crc  <= CRC_INIT;
                if (i_cmd.echo) begin
                    r_coils <= ((r_coils & ~i_cmd.mask) | (i_cmd.data & i_cmd.mask)) & CoilMask;
                end
            end else if (emit) begin
                r_valid  <= 1'b1;
                r_byte   <= cur;
                r_last   <= (r_k == last_k);
                r_ocoils <= r_coils;
                r_upd    <= r_cmd.echo;
                // The CRC is frozen once its own two bytes start to go out.
                if (r_k < last_k - 3'd1) r_crc <= crc_byte(r_crc, cur);
                r_k      <= r_k + 3'd1;
                if (r_k == last_k) r_busy <= 1'b0;
            end
        end
    end

    assign o_valid         = r_valid;
    assign o_tx_byte       = r_byte;
    assign o_tx_last       = r_last;
    assign o_coils         = r_ocoils;
    assign o_coils_updated = r_upd;

    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_k <= last_k)) else $error("response index overrun");
    a_coil_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_coils & ~CoilMask) == 16'h0000) else $error("coil beyond range set");

endmodule

### hdl/modbus_rtu_coil_slave.sv
// ----------------------------------------------------------------------------
// Modbus RTU coil slave, top level
// Accepts one input beat (received byte or millisecond tick) every cycle
// while the two-entry command queue has room; the input side stalls only
// when both entries are taken. Response beats leave one per cycle from the
// sender's output register while the receiver is ready; a response is 8
// (echo) or 5 (exception) bytes, and the sender first loads the command.
// Configuration is always ready.
// ----------------------------------------------------------------------------
module modbus_rtu_coil_slave import mrcs_pkg::*; #(
    parameter int NUM_COILS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_kind,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_last,
    output logic [15:0] o_coils,
    output logic        o_coils_updated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data
);
    logic [7:0] r_slave_addr;
    logic [7:0] r_gap_ticks;
    logic       push;
    logic       pop;
    logic       full;
    logic       empty;
    t_cmd       cmd_in;
    t_cmd       cmd_out;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slave_addr <= 8'd1;
            r_gap_ticks  <= 8'd2;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_SLAVE_ADDR) r_slave_addr <= i_cfg_data;
            if (i_cfg_index == CFG_GAP_TICKS)  r_gap_ticks  <= i_cfg_data;
        end
    end

    mrcs_front #(.NUM_COILS(NUM_COILS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_take       (i_valid && !full),
        .i_kind       (i_kind),
        .i_rx_byte    (i_rx_byte),
        .i_slave_addr (r_slave_addr),
        .i_gap_ticks  (r_gap_ticks),
        .o_push       (push),
        .o_cmd        (cmd_in)
    );

    mrcs_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_cmd   (cmd_out)
    );

    mrcs_back #(.NUM_COILS(NUM_COILS)) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_empty         (empty),
        .i_cmd           (cmd_out),
        .o_pop           (pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_tx_byte       (o_tx_byte),
        .o_tx_last       (o_tx_last),
        .o_coils         (o_coils),
        .o_coils_updated (o_coils_updated)
    );

endmodule

### bench/tb.sv
// ----------------------------------------------------------------------------
// Modbus RTU coil slave testbench
// Drives byte and tick beats into the slave, predicts every response beat
// from a behavioural model of the frame parser, CRC and coil store, and
// checks each accepted response beat field by field. Directed frames cover
// every exception, then random frames and noise follow, with
// random stalls on both sides and a quiet final stretch.
// ----------------------------------------------------------------------------
module tb;
    import mrcs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [7:0]  tx_byte;
        logic        tx_last;
        logic [15:0] coils;
        logic        coils_updated;
    } t_reply_beat;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic        i_kind;
    logic [7:0]  i_rx_byte;
    logic        o_valid;
    logic        i_ready;
    logic [7:0]  o_tx_byte;
    logic        o_tx_last;
    logic [15:0] o_coils;
    logic        o_coils_updated;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;

    modbus_rtu_coil_slave DUT (.*);

    // Model state of the slave.
    logic [7:0]  m_addr;
    logic [7:0]  m_gap;
    logic [7:0]  m_buf [32];
    logic [8:0]  m_index;
    logic [8:0]  m_length;
    logic        m_receiving;
    logic [7:0]  m_idle;
    logic [15:0] m_crc;
    logic [15:0] m_coils;

    t_reply_beat reply_q [$];
    int          errors = 0;
    bit          quiet = 0;
    int          ready_hold = 0;

    always begin
        i_clk = 1'b1; #5;
        i_clk = 1'b0; #5;
    end

    initial begin
        #20ms;
        $display("tb NOT OK");
        $finish;
    end

    function automatic logic [15:0] crc16_step(logic [15:0] acc, logic [7:0] b);
        logic [15:0] r;
        r = acc ^ {8'h00, b};
        repeat (8) begin
            if (r[0]) r = {1'b0, r[15:1]} ^ 16'hA001;
            else      r = {1'b0, r[15:1]};
        end
        return r;
    endfunction

    task automatic queue_reply(logic [7:0] bytes [], logic upd);
        t_reply_beat beat;
        for (int k = 0; k < bytes.size(); k++) begin
            beat.tx_byte = bytes[k];
            beat.tx_last = (k == bytes.size() - 1);
            beat.coils = m_coils;
            beat.coils_updated = upd;
            reply_q.push_back(beat);
        end
    endtask

    task automatic queue_exception(logic [7:0] fn, logic [7:0] code);
        logic [7:0]  r [];
        logic [15:0] c;
        r = new[5];
        r[0] = m_addr;
        r[1] = fn | EXC_FLAG;
        r[2] = code;
        c = CRC_INIT;
        for (int k = 0; k < 3; k++) c = crc16_step(c, r[k]);
        r[3] = c[7:0];
        r[4] = c[15:8];
        queue_reply(r, 1'b0);
    endtask

    task automatic close_frame();
        logic [16:0] span;
        logic [15:0] qty;
        logic [15:0] mask;
        logic [15:0] c;
        logic [7:0]  r [];
        if (m_buf[0] != m_addr) return;
        if (m_buf[1] != FN_WRITE_COILS) begin
            queue_exception(m_buf[1], EXC_ILLEGAL_FN);
            return;
        end
        if (m_crc != 16'h0000) begin
            queue_exception(FN_WRITE_COILS, EXC_CRC);
            return;
        end
        qty = {m_buf[4], m_buf[5]};
        span = {1'b0, m_buf[2], m_buf[3]} + {1'b0, qty};
        if (span > 17'd16) begin
            queue_exception(FN_WRITE_COILS, EXC_ILLEGAL_ADDR);
            return;
        end
        mask = (qty >= 16) ? 16'hFFFF : ((16'h1 << qty) - 16'h1);
        m_coils = (m_coils & ~mask) | ({m_buf[8], m_buf[7]} & mask);
        r = new[8];
        c = CRC_INIT;
        for (int k = 0; k < 6; k++) begin
            r[k] = m_buf[k];
            c = crc16_step(c, r[k]);
        end
        r[6] = c[7:0];
        r[7] = c[15:8];
        queue_reply(r, 1'b1);
    endtask

    task automatic predict_beat(logic kind, logic [7:0] b);
        if (kind) begin
            if (m_idle != 8'hFF) m_idle++;
            return;
        end
        if (m_idle > m_gap) begin
            m_receiving = 1'b1;
            m_index = 9'd0;
            m_crc = CRC_INIT;
        end
        m_idle = 8'd0;
        if (!m_receiving) return;
        if (m_index == 6) begin
            if (m_buf[1] == FN_WRITE_COILS || m_buf[1] == FN_WRITE_REGS)
                m_length = 9'd9 + b;
            else if (m_buf[1] == FN_READ_HOLD || m_buf[1] == FN_READ_INPUT)
                m_length = 9'd8;
            else
                m_length = 9'd7;
        end
        if (m_index < 32) m_buf[m_index] = b;
        m_crc = crc16_step(m_crc, b);
        m_index = m_index + 9'd1;
        if (m_index == m_length) begin
            m_index = 9'd0;
            m_receiving = 1'b0;
            m_length = 9'd0;
            close_frame();
        end
    endtask

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_beat(logic kind, logic [7:0] b);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_kind <= kind;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        predict_beat(kind, b);
        @(negedge i_clk);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (reply_q.size() != 0) @(negedge i_clk);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [7:0] idx, logic [7:0] val);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_SLAVE_ADDR) m_addr = val;
        else if (idx == CFG_GAP_TICKS) m_gap = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Sends gap ticks (not enough at a gap setting of 255), then one request frame.
    task automatic send_frame(logic [7:0] addr, logic [7:0] fn, logic [15:0] start,
                              logic [15:0] qty, logic [7:0] count, logic [15:0] data,
                              bit bad_crc, int trailing);
        logic [7:0]  f [$];
        logic [15:0] c;
        int          gap_len;
        gap_len = (m_gap == 8'hFF) ? 3 : m_gap + 1 + $urandom_range(0, 2);
        repeat (gap_len) send_beat(1'b1, 8'($urandom));
        f = '{addr, fn, start[15:8], start[7:0], qty[15:8], qty[7:0]};
        if (fn == FN_WRITE_COILS || fn == FN_WRITE_REGS) begin
            f.push_back(count);
            for (int k = 0; k < count; k++)
                f.push_back(k == 0 ? data[7:0] : k == 1 ? data[15:8] : 8'($urandom));
        end
        c = CRC_INIT;
        foreach (f[k]) c = crc16_step(c, f[k]);
        if (bad_crc) c[$urandom_range(0, 15)] ^= 1'b1;
        f.push_back(c[7:0]);
        f.push_back(c[15:8]);
        foreach (f[k]) send_beat(1'b0, f[k]);
        repeat (trailing) send_beat(1'b0, 8'($urandom));
    endtask

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    always @(negedge i_clk) begin
        if (quiet) begin
            i_ready <= 1'b1;
        end else if (ready_hold > 0) begin
            ready_hold <= ready_hold - 1;
            i_ready <= 1'b0;
        end else if ($urandom_range(0, 4) == 0) begin
            ready_hold <= $urandom_range(0, 5);
            i_ready <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_reply_beat want;
        if (i_rst_n && o_valid && i_ready) begin
            if (reply_q.size() == 0) begin
                report_mismatch("unexpected beat", 16'(o_tx_byte), 16'h0);
            end else begin
                want = reply_q.pop_front();
                if (o_tx_byte !== want.tx_byte)
                    report_mismatch("tx_byte", 16'(o_tx_byte), 16'(want.tx_byte));
                if (o_tx_last !== want.tx_last)
                    report_mismatch("tx_last", 16'(o_tx_last), 16'(want.tx_last));
                if (o_coils !== want.coils)
                    report_mismatch("coils", o_coils, want.coils);
                if (o_coils_updated !== want.coils_updated)
                    report_mismatch("coils_updated", 16'(o_coils_updated),
                                    16'(want.coils_updated));
            end
        end
    end

    task automatic test_writes();
        send_frame(8'd1, FN_WRITE_COILS, 16'd0, 16'd16, 8'd2, 16'hFFFF, 0, 0);
        send_frame(8'd1, FN_WRITE_COILS, 16'd4, 16'd12, 8'd2, 16'h5A5A, 0, 0);
        // Long frame: bytes past the buffer still enter the CRC.
        send_frame(8'd1, FN_WRITE_COILS, 16'd0, 16'd8, 8'd24, 16'h00A5, 0, 0);
    endtask

    task automatic test_exceptions();
        send_frame(8'd1, FN_WRITE_COILS, 16'd0, 16'd8, 8'd2, 16'h1234, 1, 0);
        send_frame(8'd1, FN_WRITE_COILS, 16'hFFFF, 16'hFFFF, 8'd2, 16'h1234, 0, 0);
        send_frame(8'd1, FN_WRITE_REGS, 16'd0, 16'd1, 8'd2, 16'h0001, 0, 0);
        send_frame(8'd1, FN_READ_HOLD, 16'd0, 16'd1, 8'd0, 16'h0, 0, 0);
    endtask

    task automatic test_framing();
        // Other station: dropped silently.
        send_frame(8'd7, FN_WRITE_COILS, 16'd0, 16'd4, 8'd2, 16'h000F, 0, 0);
        // Bytes straight after a frame are ignored.
        send_frame(8'd1, FN_WRITE_COILS, 16'd0, 16'd4, 8'd2, 16'h0003, 0, 2);
    endtask

    task automatic test_config();
        write_reg(CFG_SLAVE_ADDR, 8'd0);
        send_frame(8'd0, FN_WRITE_COILS, 16'd0, 16'd16, 8'd2, 16'hC3C3, 0, 0);
        write_reg(CFG_GAP_TICKS, 8'd0);
        send_frame(8'd0, 8'd5, 16'd0, 16'd0, 8'd0, 16'h0, 0, 0);
        write_reg(CFG_GAP_TICKS, 8'd255);
        // The idle count can never exceed a gap setting of 255, so nothing opens.
        repeat (4) send_beat(1'b1, 8'h00);
        send_frame(8'd0, FN_WRITE_COILS, 16'd0, 16'd2, 8'd2, 16'h0002, 0, 0);
        write_reg(CFG_GAP_TICKS, 8'd2);
        write_reg(CFG_SLAVE_ADDR, 8'd1);
    endtask

    task automatic random_frame();
        logic [7:0]  fn;
        logic [15:0] start;
        logic [15:0] qty;
        int          pick;
        pick = $urandom_range(0, 9);
        fn = (pick < 7) ? FN_WRITE_COILS : 8'($urandom);
        start = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16));
        qty = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 16));
        send_frame($urandom_range(0, 7) == 0 ? 8'($urandom) : m_addr, fn, start, qty,
                   $urandom_range(0, 9) == 0 ? 8'($urandom_range(0, 40)) : 8'd2,
                   16'($urandom), $urandom_range(0, 9) == 0, $urandom_range(0, 3) == 0);
    endtask

    task automatic test_random();
        for (int n = 0; n < 2; n++) begin
            if (n == 1) begin
                // Hold the sender off until every reply has drained.
                i_valid <= 1'b0;
                while (reply_q.size() != 0) @(negedge i_clk);
            end
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 8))
                    send_beat(1'($urandom_range(0, 1)), 8'($urandom));
            else
                random_frame();
        end
    endtask

    task automatic test_quiet();
        quiet = 1;
        random_frame();
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_kind = 1'b0;
        i_rx_byte = 8'h00;
        i_ready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_SLAVE_ADDR;
        i_cfg_data = 8'h00;
        m_addr = 8'd1;
        m_gap = 8'd2;
        foreach (m_buf[k]) m_buf[k] = 8'h00;
        m_index = 9'd0;
        m_length = 9'd0;
        m_receiving = 1'b0;
        m_idle = 8'hFF;
        m_crc = CRC_INIT;
        m_coils = 16'h0000;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_writes();
        test_exceptions();
        test_framing();
        test_config();
        test_random();
        test_quiet();

        settle();
        if (errors == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end
endmodule
